[src/rounded_mul_div_saturating_unit_assert.svh]
// Assertion macros for the rounded multiply-divide unit.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef ROUNDED_MUL_DIV_SATURATING_UNIT_ASSERT_SVH
`define ROUNDED_MUL_DIV_SATURATING_UNIT_ASSERT_SVH
// Assert that a condition implies another at the same edge.
`define RMD_ASSERT_IMPLY(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("rmd check failed");
// Assert that a condition implies another in the next cycle.
`define RMD_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("rmd check failed");
`endif

[src/rmd_pkg.sv]
// Package for the rounded multiply-divide unit: payload structs and widths.
// No dependencies.
`default_nettype none
package rmd_pkg;
  localparam int unsigned FieldW = 64;

  typedef struct packed {
    logic [FieldW-1:0] mult_a;
    logic [FieldW-1:0] mult_b;
    logic [FieldW-1:0] divisor;
  } in_item_t;

  typedef struct packed {
    logic [FieldW-1:0] quotient;
    logic              fits;
    logic              div_by_zero;
  } out_item_t;
endpackage
`default_nettype wire

[src/rmd_mul.sv]
// Pipelined multiplier: product of two W-bit operands from 32x32 partial
// products, plus half the divisor. Two register stages. No package use.
`default_nettype none
module rmd_mul #(
  parameter int unsigned W = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_vld,
  input  wire logic [W-1:0]   a,
  input  wire logic [W-1:0]   b,
  input  wire logic [W-1:0]   d,
  output logic                out_vld,
  output logic [2*W-1:0]      num,
  output logic [W-1:0]        den
);
  localparam int unsigned HW = (W + 1) / 2;
  localparam int unsigned LW = W - HW;

  logic [1:0]       vld_r;
  logic [2*HW-1:0]  p11_r, p01_r, p10_r;
  logic [2*LW-1:0]  p00_r;
  logic [W-1:0]     d1_r;
  logic [2*W-1:0]   num_r;
  logic [W-1:0]     d2_r;
  logic [2*W-1:0]   num_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    p00_r <= {{LW{1'b0}}, a[LW-1:0]} * {{LW{1'b0}}, b[LW-1:0]};
    p01_r <= {{HW{1'b0}}, HW'(a[LW-1:0])} * {{HW{1'b0}}, b[W-1:LW]};
    p10_r <= {{HW{1'b0}}, a[W-1:LW]} * {{HW{1'b0}}, HW'(b[LW-1:0])};
    p11_r <= {{HW{1'b0}}, a[W-1:LW]} * {{HW{1'b0}}, b[W-1:LW]};
    d1_r  <= d;
  end

  always_comb begin
    num_nxt = (2*W)'(p00_r)
            + ((2*W)'(p01_r) << LW)
            + ((2*W)'(p10_r) << LW)
            + ((2*W)'(p11_r) << (2*LW))
            + (2*W)'(d1_r >> 1);
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    d2_r  <= d1_r;
  end

  assign out_vld = vld_r[1];
  assign num     = num_r;
  assign den     = d2_r;
endmodule
`default_nettype wire

[src/rmd_div_stage.sv]
// One restoring-division stage: retires BITS quotient bits per register.
// Used by the top level in a chain; no package use.
`default_nettype none
module rmd_div_stage #(
  parameter int unsigned W    = 64,
  parameter int unsigned BITS = 4,
  parameter int unsigned NW   = 128
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_vld,
  input  wire logic [W-1:0]  in_rem,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [W-1:0]  in_den,
  output logic               out_vld,
  output logic [W-1:0]       out_rem,
  output logic [NW-1:0]      out_num,
  output logic [W-1:0]       out_den
);
  logic          vld_r;
  logic [W-1:0]  rem_r, den_r;
  logic [NW-1:0] num_r;
  logic [W-1:0]  rem_nxt;
  logic [NW-1:0] num_nxt;
  logic [W:0]    wide;
  logic          take;

  // num shifts left; quotient bits enter at its bottom.
  always_comb begin
    rem_nxt = in_rem;
    num_nxt = in_num;
    wide    = '0;
    take    = 1'b0;
    for (int i = 0; i < BITS; i++) begin
      wide    = {rem_nxt, num_nxt[NW-1]};
      take    = (wide >= {1'b0, in_den});
      wide    = take ? wide - {1'b0, in_den} : wide;
      rem_nxt = wide[W-1:0];
      num_nxt = {num_nxt[NW-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= in_den;
  end

  assign out_vld = vld_r;
  assign out_rem = rem_r;
  assign out_num = num_r;
  assign out_den = den_r;
endmodule
`default_nettype wire

[src/rounded_mul_div_saturating_unit.sv]
// Top level of the rounded multiply-divide unit.
// Uses rmd_pkg, rmd_mul, rmd_div_stage and the assertion macro header.
//
// Usage: drive in_item and pulse start; busy is always low, so one operand
// triple is taken every cycle. Each result appears on out_item for exactly
// one cycle with out_vld high, after passing through two multiplier stages,
// the division chain of 32 stages (at the defaults) retiring four quotient
// bits each, and an output register. Throughput is one item per cycle.
// quotient = floor((a*b + floor(c/2)) / c), saturated to all ones of
// OPERAND_WIDTH bits with fits low when it does not fit; a zero divisor
// gives all ones, fits low and div_by_zero high. Bits of the operands at
// or above OPERAND_WIDTH are ignored.
// Reset clears every valid bit in the pipeline; items in flight are dropped.
// The receiver cannot stall: out_vld is a strobe and must be taken.
`default_nettype none
module rounded_mul_div_saturating_unit #(
  parameter int unsigned OPERAND_WIDTH = 64,
  parameter int unsigned DIV_BITS      = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire rmd_pkg::in_item_t in_item,
  output logic                   out_vld,
  output rmd_pkg::out_item_t     out_item
);
  `include "rounded_mul_div_saturating_unit_assert.svh"

  localparam int unsigned W      = OPERAND_WIDTH;
  localparam int unsigned NSTAGE = (2*W + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned NW     = NSTAGE*DIV_BITS;

  logic           acc;
  logic           m_vld;
  logic [2*W-1:0] m_num;
  logic [W-1:0]   m_den;

  logic           s_vld [NSTAGE+1];
  logic [W-1:0]   s_rem [NSTAGE+1];
  logic [NW-1:0]  s_num [NSTAGE+1];
  logic [W-1:0]   s_den [NSTAGE+1];

  logic           vld_r;
  rmd_pkg::out_item_t res_r, res_nxt;
  logic           dz;
  logic           ovf;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  rmd_mul #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .in_vld(acc),
    .a(in_item.mult_a[W-1:0]), .b(in_item.mult_b[W-1:0]),
    .d(in_item.divisor[W-1:0]),
    .out_vld(m_vld), .num(m_num), .den(m_den)
  );

  // Zero-extend the numerator to a whole number of stages; the extra
  // leading steps only produce quotient zeros.
  assign s_vld[0] = m_vld;
  assign s_rem[0] = '0;
  assign s_num[0] = NW'(m_num);
  assign s_den[0] = m_den;

  for (genvar g = 0; g < NSTAGE; g++) begin : g_div
    rmd_div_stage #(.W(W), .BITS(DIV_BITS), .NW(NW)) u_stage (
      .clk(clk), .rst_n(rst_n),
      .in_vld(s_vld[g]), .in_rem(s_rem[g]), .in_num(s_num[g]),
      .in_den(s_den[g]),
      .out_vld(s_vld[g+1]), .out_rem(s_rem[g+1]), .out_num(s_num[g+1]),
      .out_den(s_den[g+1])
    );
  end

  always_comb begin
    dz  = (s_den[NSTAGE] == '0);
    ovf = |s_num[NSTAGE][NW-1:W];
    res_nxt = '0;
    res_nxt.div_by_zero = dz;
    if (dz || ovf) begin
      res_nxt.quotient = {{(rmd_pkg::FieldW-W){1'b0}}, {W{1'b1}}};
      res_nxt.fits     = 1'b0;
    end else begin
      res_nxt.quotient = {{(rmd_pkg::FieldW-W){1'b0}}, s_num[NSTAGE][W-1:0]};
      res_nxt.fits     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= s_vld[NSTAGE];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_vld  = vld_r;
  assign out_item = res_r;

  `RMD_ASSERT_IMPLY(a_fits_excl, out_vld, !(out_item.fits && out_item.div_by_zero))
  `RMD_ASSERT_IMPLY(a_sat_ones, out_vld && !out_item.fits, out_item.quotient[W-1:0] == {W{1'b1}})
  `RMD_ASSERT_NEXT(a_mul_flow, m_vld, s_vld[1])
endmodule
`default_nettype wire

[tb/sv/tb_rounded_mul_div_saturating_unit.sv]
// Testbench for the rounded multiply-divide unit: drives operand triples,
// predicts each rounded, saturated quotient and checks it. Uses rmd_pkg.
`default_nettype none
module tb_rounded_mul_div_saturating_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OpW = 64;
  localparam int unsigned LatencyCycles = 35;
  localparam longint unsigned CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  rmd_pkg::in_item_t in_item = '0;
  logic out_vld;
  rmd_pkg::out_item_t out_item;

  rmd_pkg::out_item_t quot_q[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_sat = 0;
  int unsigned n_dbz = 0;
  longint unsigned cycle = 0;
  bit no_idle = 1'b0;

  rounded_mul_div_saturating_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_vld(out_vld), .out_item(out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CycleLimit) begin
      $display("%0t timeout", $time);
      $display("** rounded_mul_div_saturating_unit: FAILED **");
      $finish;
    end
  end

  function automatic rmd_pkg::out_item_t predict_quotient(rmd_pkg::in_item_t it);
    rmd_pkg::out_item_t r;
    logic [2*OpW-1:0] num;
    logic [2*OpW-1:0] q;
    r = '0;
    if (it.divisor == '0) begin
      r.quotient = '1;
      r.div_by_zero = 1'b1;
    end else begin
      num = it.mult_a * {{OpW{1'b0}}, it.mult_b} + (it.divisor >> 1);
      q = num / {{OpW{1'b0}}, it.divisor};
      if (q[2*OpW-1:OpW] == '0) begin
        r.quotient = q[OpW-1:0];
        r.fits = 1'b1;
      end else begin
        r.quotient = '1;
      end
    end
    return r;
  endfunction

  // check each result strobe against the oldest prediction
  always @(posedge clk) begin
    rmd_pkg::out_item_t exp_r;
    if (rst_n && out_vld) begin
      if (quot_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_item);
        errors++;
      end else begin
        exp_r = quot_q.pop_front();
        n_checked++;
        if (!exp_r.fits) n_sat++;
        if (exp_r.div_by_zero) n_dbz++;
        if (out_item.quotient !== exp_r.quotient) begin
          $display("%0t quotient exp %h got %h", $time, exp_r.quotient, out_item.quotient);
          errors++;
        end
        if (out_item.fits !== exp_r.fits) begin
          $display("%0t fits exp %b got %b", $time, exp_r.fits, out_item.fits);
          errors++;
        end
        if (out_item.div_by_zero !== exp_r.div_by_zero) begin
          $display("%0t div_by_zero exp %b got %b", $time, exp_r.div_by_zero,
                   out_item.div_by_zero);
          errors++;
        end
      end
    end
  end

  function automatic logic [OpW-1:0] rand_op();
    logic [OpW-1:0] v;
    int unsigned nbits;
    v = {$urandom, $urandom};
    nbits = $urandom_range(OpW, 1);
    case ($urandom_range(5, 0))
      0: v = v >> (OpW - nbits);
      1: v = '1 >> $urandom_range(OpW - 1, 0);
      2: v = OpW'(1) << $urandom_range(OpW - 1, 0);
      default: ;
    endcase
    return v;
  endfunction

  // transfer one triple; optionally idle first
  task automatic send_triple(logic [OpW-1:0] a, logic [OpW-1:0] b, logic [OpW-1:0] c);
    rmd_pkg::in_item_t it;
    it.mult_a = a;
    it.mult_b = b;
    it.divisor = c;
    if (!no_idle) begin
      while ($urandom_range(99, 0) < 20) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    quot_q.push_back(predict_quotient(it));
    n_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (quot_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [OpW-1:0] mx;
    mx = '1;
    send_triple(0, 0, 0);
    send_triple(mx, mx, 0);
    send_triple(mx, mx, mx);
    send_triple(mx, mx, 1);
    send_triple(mx, 1, 1);
    send_triple(mx, 1, 2);
    send_triple(mx, 2, 2);
    send_triple(mx, 2, 3);
    send_triple(0, mx, 1);
    send_triple(7, 1, 2);
    send_triple(5, 1, 2);
    send_triple(1, 1, mx);
    send_triple(mx, mx - 1, mx);
    send_triple(64'h8000_0000_0000_0000, 2, 1);
    send_triple(64'hFFFF_FFFF, 64'hFFFF_FFFF, 3);
    send_triple(10, 10, 64'h8000_0000_0000_0000);
    send_triple(mx, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_triple(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, mx);
  endtask

  task automatic test_random(int unsigned count);
    logic [OpW-1:0] a;
    logic [OpW-1:0] b;
    logic [OpW-1:0] c;
    for (int unsigned i = 0; i < count; i++) begin
      a = rand_op();
      b = rand_op();
      c = ($urandom_range(19, 0) == 0) ? '0 : rand_op();
      send_triple(a, b, c);
    end
  endtask

  task automatic test_back_to_back(int unsigned count);
    no_idle = 1'b1;
    test_random(count);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain_results();
    test_random(600);
    test_back_to_back(300);
    drain_results();
    test_random(380);
    drain_results();
    repeat (LatencyCycles + 10) @(posedge clk);
    $display("Checked %0d of %0d triples: %0d saturated, %0d divide-by-zero.",
             n_checked, n_sent, n_sat, n_dbz);
    if (errors == 0 && quot_q.size() == 0) begin
      $display("** rounded_mul_div_saturating_unit: PASSED **");
    end else begin
      $display("** rounded_mul_div_saturating_unit: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
+incdir+src
src/rmd_pkg.sv
src/rmd_mul.sv
src/rmd_div_stage.sv
src/rounded_mul_div_saturating_unit.sv
tb/sv/tb_rounded_mul_div_saturating_unit.sv
